[src/fcne_pkg.sv]
// ----------------------------------------------------------------------------
// fcne_pkg: shared constants, codes and types
// Widths, codes and the controller-datapath interface of the equaliser.
// ----------------------------------------------------------------------------
package fcne_pkg;

    // Filter and averaging sizes. DISP_WINDOW must be a power of two.
    localparam int TAP_COUNT     = 32;
    localparam int DISP_WINDOW   = 512;
    localparam int PRIME_SAMPLES = 256;

    localparam int IDX_W   = $clog2(TAP_COUNT);
    localparam int FILL_W  = $clog2(TAP_COUNT + 1);
    localparam int DSH     = $clog2(DISP_WINDOW);
    localparam int DCNT_W  = $clog2(DISP_WINDOW + 1);
    localparam int PRIME_W = $clog2(PRIME_SAMPLES + 1);

    // Accumulator, energy and divider widths.
    localparam int ACC_W = 48 + IDX_W + 1;
    localparam int EN_W  = 46 + IDX_W + 1;
    localparam int NUM_W = 62;
    localparam int QUO_W = 26;
    localparam int SAT_W = 40;

    // Fixed-point constants.
    localparam logic [23:0] ONE_Q18   = 24'd262144;
    localparam logic [23:0] TENTH_Q18 = 24'd26214;
    localparam logic [23:0] LEVEL_ONE = 24'd256;
    localparam logic [23:0] DISP_ONE  = 24'd65536;
    localparam logic [15:0] STEP_RST  = 16'd655;
    localparam int          ERR_LIM   = 1048576;
    localparam int          EPS_Q36   = 68719;

    // Command, mode and register codes.
    localparam logic [1:0] CMD_SAMPLE   = 2'd0;
    localparam logic [1:0] CMD_DECISION = 2'd1;
    localparam logic [1:0] CMD_TAP      = 2'd2;
    localparam logic [1:0] MODE_FROZEN  = 2'd0;
    localparam logic [1:0] MODE_CMA     = 2'd1;
    localparam logic [1:0] MODE_DD      = 2'd2;
    localparam logic       REG_MODE     = 1'b0;
    localparam logic       REG_STEP     = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic tap_wr;
        logic dc_upd;
        logic lvl_upd;
        logic xdiv_start;
        logic push;
        logic mac;
        logic y_calc;
        logic y2_calc;
        logic err_calc;
        logic disp_upd;
        logic dec_eval;
        logic en_acc;
        logic mul1;
        logic mul2;
        logic ndiv_start;
        logic tap_upd;
        logic out_load;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] mode;
        logic       held_valid;
        logic       emit;
        logic       gate_ok;
        logic       div_busy;
        logic       idx_last;
        logic       out_busy;
    } sts_t;

    // Saturate a signed value to 24 bits.
    function automatic logic [23:0] sat24(input logic signed [SAT_W-1:0] v);
        logic [23:0] r;
        if (v > $signed(SAT_W'(8388607)))
        begin
            r = 24'h7FFFFF;
        end
        else if (v < -$signed(SAT_W'(8388608)))
        begin
            r = 24'h800000;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

[src/fcne_div.sv]
// ----------------------------------------------------------------------------
// fcne_div: iterative unsigned divider
// Restoring division, one quotient bit a cycle, saturating quotient.
// ----------------------------------------------------------------------------
module fcne_div
    import fcne_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [EN_W-1:0]  den,
    output logic             busy,
    output logic [QUO_W-1:0] quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [EN_W-1:0]  rem_reg,  rem_next;
    logic [EN_W-1:0]  den_reg,  den_next;
    logic [QUO_W-1:0] lo_reg,   lo_next;
    logic [QUO_W-1:0] quo_reg,  quo_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [EN_W:0]    trial;
    logic             ge;
    logic             ovf;

    // The quotient saturates when the top part already reaches the divisor.
    assign ovf   = NUM_W'(num[NUM_W-1:QUO_W]) >= NUM_W'(den);
    assign trial = {rem_reg, lo_reg[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_reg};

    // Next-state logic of the shift-subtract loop.
    always_comb
    begin
        rem_next = rem_reg;
        den_next = den_reg;
        lo_next  = lo_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            den_next = den;
            lo_next  = num[QUO_W-1:0];
            rem_next = EN_W'(num[NUM_W-1:QUO_W]);
            if (ovf)
            begin
                quo_next = '1;
                cnt_next = '0;
            end
            else
            begin
                quo_next = '0;
                cnt_next = CNT_W'(QUO_W);
            end
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? EN_W'(trial - {1'b0, den_reg}) : trial[EN_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            lo_next  = {lo_reg[QUO_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Iteration counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;

endmodule

[src/fcne_dp.sv]
// ----------------------------------------------------------------------------
// fcne_dp: equaliser datapath
// Front end, delay line, taps, FIR accumulator, NLMS update and statistics.
// ----------------------------------------------------------------------------
module fcne_dp
    import fcne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    output sts_t               sts,
    input  logic               cfg_fire,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [1:0]         cmd,
    input  logic signed [15:0] sample,
    input  logic signed [23:0] decision,
    input  logic [22:0]        tolerance,
    input  logic [4:0]         tap_index,
    input  logic signed [23:0] tap_value,
    input  logic               load_done,
    input  logic               parity,
    input  logic               out_ready,
    output logic               out_valid,
    output logic signed [23:0] equalized_output,
    output logic [23:0]        dispersion,
    output logic [23:0]        agc_level,
    output logic [31:0]        symbol_count,
    output logic [31:0]        decisions_used,
    output logic [31:0]        decisions_rejected
);

    // Configuration and front-end state.
    logic [1:0]         mode_reg;
    logic [15:0]        step_reg;
    logic               frozen_reg;
    logic signed [15:0] sample_reg;
    logic signed [23:0] decision_reg;
    logic [22:0]        tol_reg;
    logic signed [31:0] dc_reg;
    logic [23:0]        level_reg;
    logic [PRIME_W-1:0] prime_reg;
    logic               half_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               emit_reg;
    logic               xsign_reg;

    // Filter state.
    logic signed [23:0] tap_reg   [TAP_COUNT];
    logic signed [23:0] dline_reg [TAP_COUNT];
    logic [IDX_W-1:0]   idx_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [23:0] y_reg;
    logic [28:0]        y2_reg;
    logic signed [21:0] err_reg;
    logic [37:0]        term_reg;
    logic [EN_W-1:0]    en_reg;
    logic [44:0]        p1_reg;
    logic [NUM_W-1:0]   num_reg;

    // Held output and statistics.
    logic signed [23:0] held_reg;
    logic               held_valid_reg;
    logic [31:0]        used_reg;
    logic [31:0]        rej_reg;
    logic [39:0]        dsum_reg;
    logic [DCNT_W-1:0]  dcnt_reg;
    logic [23:0]        dval_reg;
    logic [31:0]        ocnt_reg;

    // Result register.
    logic               out_valid_reg;
    logic signed [23:0] out_y_reg;
    logic [23:0]        out_disp_reg;
    logic [23:0]        out_level_reg;
    logic [31:0]        out_sym_reg;
    logic [31:0]        out_used_reg;
    logic [31:0]        out_rej_reg;

    // Combinational helpers.
    logic signed [33:0] diff;
    logic [33:0]        diff_mag;
    logic [24:0]        a_val;
    logic signed [25:0] dl;
    logic signed [38:0] pm;
    logic signed [26:0] lvl_raw;
    logic [23:0]        lvl_new;
    logic [23:0]        xq;
    logic [23:0]        xval;
    logic               half_new;
    logic [FILL_W-1:0]  fill_new;
    logic signed [23:0] tap_cur;
    logic signed [23:0] x_cur;
    logic [23:0]        xm;
    logic signed [47:0] mac_prod;
    logic signed [47:0] ysq;
    logic signed [29:0] onem;
    logic signed [53:0] cma_prod;
    logic signed [35:0] cma_err;
    logic signed [29:0] dd;
    logic [28:0]        dmag;
    logic [57:0]        dsq;
    logic [40:0]        dsum_add;
    logic [39:0]        dsum_new;
    logic [39:0]        dshift;
    logic signed [24:0] dec_err;
    logic [24:0]        dec_mag;
    logic [20:0]        em;
    logic [60:0]        p2;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [EN_W-1:0]    div_den;
    logic               div_busy;
    logic [QUO_W-1:0]   div_q;
    logic signed [27:0] tap_sum;
    logic               upd_neg;

    // Divider shared by the sample normalisation and the NLMS step.
    assign div_start = ctl.xdiv_start | ctl.ndiv_start;
    assign div_num   = ctl.xdiv_start ? (NUM_W'(diff_mag) << 10) : num_reg;
    assign div_den   = ctl.xdiv_start ? EN_W'(level_reg) : en_reg;

    fcne_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_q)
    );

    // DC-removed sample and its magnitude.
    assign diff     = {{2{sample_reg[15]}}, sample_reg, 16'h0000}
                    - {{2{dc_reg[31]}}, dc_reg};
    assign diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
    assign a_val    = diff_mag[32:8];

    // Level tracking: fast priming average, then slow leak (held when frozen), then clamp.
    assign dl = $signed({1'b0, a_val}) - $signed({2'b00, level_reg});
    assign pm = 39'(dl) * 39'sd3277;
    always_comb
    begin
        if (prime_reg != '0)
        begin
            if (prime_reg == PRIME_W'(PRIME_SAMPLES))
            begin
                lvl_raw = $signed({2'b00, a_val});
            end
            else
            begin
                lvl_raw = $signed({3'b000, level_reg}) + 27'(pm >>> 16);
            end
        end
        else if (!frozen_reg)
        begin
            lvl_raw = $signed({3'b000, level_reg}) + 27'(dl >>> 11);
        end
        else
        begin
            lvl_raw = $signed({3'b000, level_reg});
        end
        if (lvl_raw < $signed({3'b000, LEVEL_ONE}))
        begin
            lvl_new = LEVEL_ONE;
        end
        else if (lvl_raw > $signed(27'h0FFFFFF))
        begin
            lvl_new = 24'hFFFFFF;
        end
        else
        begin
            lvl_new = lvl_raw[23:0];
        end
    end

    // Normalised sample, saturated to the signed 24-bit range.
    always_comb
    begin
        xq = (div_q > QUO_W'(24'h800000)) ? 24'h800000 : div_q[23:0];
        if (xsign_reg)
        begin
            xval = 24'(-xq);
        end
        else
        begin
            xval = (xq == 24'h800000) ? 24'h7FFFFF : xq;
        end
    end
    assign half_new = ~half_reg;
    assign fill_new = (fill_reg < FILL_W'(TAP_COUNT)) ? fill_reg + 1'b1 : fill_reg;

    // Per-tap operands at the running index.
    assign tap_cur  = tap_reg[idx_reg];
    assign x_cur    = dline_reg[idx_reg];
    assign xm       = x_cur[23] ? 24'(-x_cur) : x_cur;
    assign mac_prod = tap_cur * x_cur;

    // Output power, CMA error and dispersion term.
    assign ysq      = y_reg * y_reg;
    assign onem     = $signed({6'b0, ONE_Q18}) - $signed({1'b0, y2_reg});
    assign cma_prod = 54'(y_reg) * 54'(onem);
    assign cma_err  = 36'(cma_prod >>> 18);
    assign dd       = $signed({1'b0, y2_reg}) - $signed({6'b0, ONE_Q18});
    assign dmag     = dd[29] ? 29'(-dd) : 29'(dd);
    assign dsq      = dmag * dmag;
    assign dsum_add = {1'b0, dsum_reg} + 41'(term_reg);
    assign dsum_new = dsum_add[40] ? '1 : dsum_add[39:0];
    assign dshift   = dsum_new >> DSH;

    // Decision error and trust gate.
    assign dec_err = $signed({decision_reg[23], decision_reg})
                   - $signed({held_reg[23], held_reg});
    assign dec_mag = dec_err[24] ? 25'(-dec_err) : 25'(dec_err);

    // NLMS magnitudes and update.
    assign em      = err_reg[21] ? 21'(-err_reg) : 21'(err_reg);
    assign p2      = 61'(p1_reg) * 61'(step_reg);
    assign upd_neg = err_reg[21] ^ x_cur[23];
    assign tap_sum = upd_neg ? 28'(tap_cur) - $signed({2'b00, div_q})
                             : 28'(tap_cur) + $signed({2'b00, div_q});

    // Configuration, front-end and statistics control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_FROZEN;
            step_reg       <= STEP_RST;
            frozen_reg     <= 1'b0;
            dc_reg         <= '0;
            level_reg      <= LEVEL_ONE;
            prime_reg      <= PRIME_W'(PRIME_SAMPLES);
            half_reg       <= 1'b0;
            fill_reg       <= '0;
            emit_reg       <= 1'b0;
            idx_reg        <= '0;
            held_valid_reg <= 1'b0;
            used_reg       <= '0;
            rej_reg        <= '0;
            dsum_reg       <= '0;
            dcnt_reg       <= '0;
            dval_reg       <= DISP_ONE;
            ocnt_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                if (cfg_index == REG_MODE)
                begin
                    mode_reg <= cfg_data[1:0];
                    if (cfg_data[1:0] != MODE_CMA)
                    begin
                        frozen_reg <= 1'b1;
                    end
                end
                else if (cfg_data != '0)
                begin
                    step_reg <= cfg_data;
                end
            end
            if (ctl.tap_wr && load_done)
            begin
                half_reg   <= parity;
                level_reg  <= LEVEL_ONE;
                prime_reg  <= '0;
                frozen_reg <= 1'b1;
            end
            if (ctl.dc_upd && !frozen_reg)
            begin
                dc_reg <= 32'($signed({{2{dc_reg[31]}}, dc_reg}) + (diff >>> 13));
            end
            if (ctl.lvl_upd)
            begin
                level_reg <= lvl_new;
                if (prime_reg != '0)
                begin
                    prime_reg <= prime_reg - 1'b1;
                end
            end
            if (ctl.push)
            begin
                half_reg <= half_new;
                fill_reg <= fill_new;
                emit_reg <= !half_new && (fill_new >= FILL_W'(TAP_COUNT))
                            && (prime_reg == '0);
            end
            // Running tap index wraps after every full pass.
            if (ctl.mac || ctl.en_acc || ctl.tap_upd)
            begin
                idx_reg <= (idx_reg == IDX_W'(TAP_COUNT - 1)) ? '0 : idx_reg + 1'b1;
            end
            if (ctl.disp_upd)
            begin
                if (mode_reg == MODE_DD)
                begin
                    held_valid_reg <= 1'b1;
                end
                if (dcnt_reg + 1'b1 >= DCNT_W'(DISP_WINDOW))
                begin
                    dval_reg <= (dshift > 40'hFFFFFF) ? 24'hFFFFFF : dshift[23:0];
                    dsum_reg <= '0;
                    dcnt_reg <= '0;
                end
                else
                begin
                    dsum_reg <= dsum_new;
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
                if (ocnt_reg != '1)
                begin
                    ocnt_reg <= ocnt_reg + 1'b1;
                end
            end
            if (ctl.dec_eval)
            begin
                held_valid_reg <= 1'b0;
                if (sts.gate_ok)
                begin
                    if (used_reg != '1)
                    begin
                        used_reg <= used_reg + 1'b1;
                    end
                end
                else if (rej_reg != '1)
                begin
                    rej_reg <= rej_reg + 1'b1;
                end
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Taps and delay line reset to their starting contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < TAP_COUNT; j++)
            begin
                tap_reg[j]   <= '0;
                dline_reg[j] <= '0;
            end
            tap_reg[TAP_COUNT / 2]     <= ONE_Q18;
            tap_reg[TAP_COUNT / 2 + 1] <= TENTH_Q18;
        end
        else
        begin
            if (ctl.tap_wr && (32'(tap_index) < TAP_COUNT))
            begin
                tap_reg[IDX_W'(tap_index)] <= tap_value;
            end
            if (ctl.tap_upd)
            begin
                tap_reg[idx_reg] <= sat24(SAT_W'(tap_sum));
            end
            if (ctl.push)
            begin
                for (int j = TAP_COUNT - 1; j > 0; j--)
                begin
                    dline_reg[j] <= dline_reg[j - 1];
                end
                dline_reg[0] <= xval;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            sample_reg   <= sample;
            decision_reg <= decision;
            tol_reg      <= tolerance;
        end
        if (ctl.xdiv_start)
        begin
            xsign_reg <= diff[33];
        end
        if (ctl.push)
        begin
            acc_reg <= '0;
        end
        else if (ctl.mac)
        begin
            acc_reg <= acc_reg + ACC_W'(mac_prod);
        end
        if (ctl.y_calc)
        begin
            y_reg <= sat24(SAT_W'((acc_reg + ACC_W'(131072)) >>> 18));
        end
        if (ctl.y2_calc)
        begin
            y2_reg <= ysq[46:18];
        end
        if (ctl.err_calc)
        begin
            term_reg <= dsq[57:20];
            if (cma_err > 36'sd1048576)
            begin
                err_reg <= 22'(ERR_LIM);
            end
            else if (cma_err < -36'sd1048576)
            begin
                err_reg <= -22'(ERR_LIM);
            end
            else
            begin
                err_reg <= cma_err[21:0];
            end
        end
        if (ctl.dec_eval)
        begin
            if (dec_err > 25'sd1048576)
            begin
                err_reg <= 22'(ERR_LIM);
            end
            else if (dec_err < -25'sd1048576)
            begin
                err_reg <= -22'(ERR_LIM);
            end
            else
            begin
                err_reg <= dec_err[21:0];
            end
        end
        if (ctl.disp_upd)
        begin
            // Only decision-directed mode keeps the output for a later decision.
            if (mode_reg == MODE_DD)
            begin
                held_reg <= y_reg;
            end
            en_reg <= EN_W'(EPS_Q36);
        end
        if (ctl.dec_eval)
        begin
            en_reg <= EN_W'(EPS_Q36);
        end
        if (ctl.en_acc)
        begin
            en_reg <= en_reg + EN_W'(xm * xm);
        end
        if (ctl.mul1)
        begin
            p1_reg <= em * xm;
        end
        if (ctl.mul2)
        begin
            num_reg <= NUM_W'({p2, 2'b00});
        end
        if (ctl.out_load)
        begin
            out_y_reg     <= y_reg;
            out_disp_reg  <= dval_reg;
            out_level_reg <= level_reg;
            out_sym_reg   <= ocnt_reg;
            out_used_reg  <= used_reg;
            out_rej_reg   <= rej_reg;
        end
    end

    // Status towards the controller.
    always_comb
    begin
        sts.cmd        = cmd;
        sts.mode       = mode_reg;
        sts.held_valid = held_valid_reg;
        sts.emit       = emit_reg;
        sts.gate_ok    = !((tol_reg != '0) && ({dec_mag, 1'b0} > 26'(tol_reg)));
        sts.div_busy   = div_busy;
        sts.idx_last   = idx_reg == IDX_W'(TAP_COUNT - 1);
        sts.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid          = out_valid_reg;
    assign equalized_output   = out_y_reg;
    assign dispersion         = out_disp_reg;
    assign agc_level          = out_level_reg;
    assign symbol_count       = out_sym_reg;
    assign decisions_used     = out_used_reg;
    assign decisions_rejected = out_rej_reg;

endmodule

[src/fcne_ctrl.sv]
// ----------------------------------------------------------------------------
// fcne_ctrl: equaliser sequencer
// One-hot state machine that steps the datapath through each command.
// ----------------------------------------------------------------------------
module fcne_ctrl
    import fcne_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output ctl_t ctl
);

    typedef enum logic [18:0] {
        ST_IDLE  = 19'd1,
        ST_DC    = 19'd2,
        ST_LVL   = 19'd4,
        ST_XDIV  = 19'd8,
        ST_XWAIT = 19'd16,
        ST_PUSH  = 19'd32,
        ST_FIR   = 19'd64,
        ST_Y     = 19'd128,
        ST_Y2    = 19'd256,
        ST_ERR   = 19'd512,
        ST_DISP  = 19'd1024,
        ST_DEC   = 19'd2048,
        ST_NRG   = 19'd4096,
        ST_MUL1  = 19'd8192,
        ST_MUL2  = 19'd16384,
        ST_NDIV  = 19'd32768,
        ST_NWAIT = 19'd65536,
        ST_UPD   = 19'd131072,
        ST_OUT   = 19'd262144
    } state_t;

    state_t state_reg, state_next;
    logic   ret_out_reg, ret_out_next;
    logic   fire;

    assign in_ready = state_reg == ST_IDLE;
    assign fire     = in_valid && in_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next   = state_reg;
        ret_out_next = ret_out_reg;
        ctl          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.latch = fire;
                if (fire)
                begin
                    case (sts.cmd)
                        CMD_SAMPLE:
                        begin
                            state_next = ST_DC;
                        end
                        CMD_DECISION:
                        begin
                            if (sts.held_valid && sts.mode == MODE_DD)
                            begin
                                state_next = ST_DEC;
                            end
                        end
                        CMD_TAP:
                        begin
                            ctl.tap_wr = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DC:
            begin
                ctl.dc_upd = 1'b1;
                state_next = ST_LVL;
            end
            ST_LVL:
            begin
                ctl.lvl_upd = 1'b1;
                state_next  = ST_XDIV;
            end
            ST_XDIV:
            begin
                ctl.xdiv_start = 1'b1;
                state_next     = ST_XWAIT;
            end
            ST_XWAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                ctl.push   = 1'b1;
                state_next = ST_FIR;
            end
            ST_FIR:
            begin
                // A symbol is only computed on the output phase.
                if (!sts.emit)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.mac = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = ST_Y;
                    end
                end
            end
            ST_Y:
            begin
                ctl.y_calc = 1'b1;
                state_next = ST_Y2;
            end
            ST_Y2:
            begin
                ctl.y2_calc = 1'b1;
                state_next  = ST_ERR;
            end
            ST_ERR:
            begin
                ctl.err_calc = 1'b1;
                state_next   = ST_DISP;
            end
            ST_DISP:
            begin
                ctl.disp_upd = 1'b1;
                ret_out_next = 1'b1;
                state_next   = (sts.mode == MODE_CMA) ? ST_NRG : ST_OUT;
            end
            ST_DEC:
            begin
                ctl.dec_eval = 1'b1;
                ret_out_next = 1'b0;
                state_next   = sts.gate_ok ? ST_NRG : ST_IDLE;
            end
            ST_NRG:
            begin
                ctl.en_acc = 1'b1;
                if (sts.idx_last)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                ctl.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                ctl.mul2   = 1'b1;
                state_next = ST_NDIV;
            end
            ST_NDIV:
            begin
                ctl.ndiv_start = 1'b1;
                state_next     = ST_NWAIT;
            end
            ST_NWAIT:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                ctl.tap_upd = 1'b1;
                if (!sts.idx_last)
                begin
                    state_next = ST_MUL1;
                end
                else
                begin
                    state_next = ret_out_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT:
            begin
                // Wait for the result register to free up.
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ret_out_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_out_reg <= ret_out_next;
        end
    end

endmodule

[src/fractional_cma_nlms_equalizer.sv]
// ----------------------------------------------------------------------------
// fractional_cma_nlms_equalizer: T/2 adaptive FIR equaliser
// A line sample is normalised by the 26-step divider; an output sample also
//   runs the 32-tap MAC.
// Adaptation (CMA output or accepted decision) adds an energy pass over the
//   32 taps plus one divide for each tap.
// One item is in work at a time; a result waits in its own output register.
// Reset is asynchronous and immediate: taps, delay line and counters return
//   to their starting values at once, with no clearing pass.
// ----------------------------------------------------------------------------
module fractional_cma_nlms_equalizer
    import fcne_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         cmd,
    input  logic signed [15:0] sample,
    input  logic signed [23:0] decision,
    input  logic [22:0]        tolerance,
    input  logic [4:0]         tap_index,
    input  logic signed [23:0] tap_value,
    input  logic               load_done,
    input  logic               parity,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] equalized_output,
    output logic [23:0]        dispersion,
    output logic [23:0]        agc_level,
    output logic [31:0]        symbol_count,
    output logic [31:0]        decisions_used,
    output logic [31:0]        decisions_rejected,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);

    ctl_t ctl;
    sts_t sts;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    fcne_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    fcne_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .sts                (sts),
        .cfg_fire           (cfg_valid && cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .cmd                (cmd),
        .sample             (sample),
        .decision           (decision),
        .tolerance          (tolerance),
        .tap_index          (tap_index),
        .tap_value          (tap_value),
        .load_done          (load_done),
        .parity             (parity),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .equalized_output   (equalized_output),
        .dispersion         (dispersion),
        .agc_level          (agc_level),
        .symbol_count       (symbol_count),
        .decisions_used     (decisions_used),
        .decisions_rejected (decisions_rejected)
    );

endmodule

[src/fcne_checker.sv]
// ----------------------------------------------------------------------------
// fcne_checker: port-level checks for the equaliser
// Watches the top-level ports and flags behaviour the design must not show.
// ----------------------------------------------------------------------------
module fcne_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [23:0] equalized_output,
    input logic [23:0] agc_level
);

    // A result held back by the consumer stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(equalized_output))
        else $error("result changed while stalled");

    // The input side only closes after a transfer.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
        else $error("input closed without a transfer");

    // A new result appears only while the block is busy with a sample.
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared while idle");

    // The level estimate never drops below unity.
    a_level_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> agc_level >= 24'd256)
        else $error("level estimate below unity");

endmodule

bind fractional_cma_nlms_equalizer fcne_checker u_fcne_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .equalized_output (equalized_output),
    .agc_level        (agc_level)
);
